### rtl/slt_pkg.sv
// Package for the sequential list table.
// Holds the command and status codes, the field widths and the result record.
// Used by slt_ctrl and sequential_list_table; depends on nothing.
package slt_pkg;

  // Widths fixed by the item format.
  localparam int KEY_W     = 32;
  localparam int PAY_MAX_W = 64;
  localparam int POS_W     = 4;
  localparam int CAP_W     = 5;
  localparam int CNT_OUT_W = 5;

  // Command codes carried by each input item.
  typedef enum logic [2:0] {
    CMD_INS_END    = 3'd0,
    CMD_INS_FRONT  = 3'd1,
    CMD_INS_SORTED = 3'd2,
    CMD_REM_END    = 3'd3,
    CMD_REM_FRONT  = 3'd4,
    CMD_REM_AT     = 3'd5,
    CMD_READ_AT    = 3'd6,
    CMD_FIND_KEY   = 3'd7
  } cmd_e;

  // Status codes reported with each result.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_BAD_POS = 3'd3,
    ST_NO_KEY  = 3'd4
  } status_e;

  // One result record as it leaves the sequencer.
  typedef struct packed {
    status_e               status;
    logic [POS_W-1:0]      found_position;
    logic [KEY_W-1:0]      key;
    logic [PAY_MAX_W-1:0]  payload;
    logic [CNT_OUT_W-1:0]  count;
    logic                  is_full;
    logic                  is_empty;
  } rsp_t;

endpackage

### rtl/slt_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Parameterised in width and depth; depends on nothing.
module slt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; a read of the address being written returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/slt_ctrl.sv
// Command sequencer of the sequential list table.
// Walks the entry memory one entry per cycle to scan, shift, insert and remove.
// Depends on slt_pkg and slt_ram.
module slt_ctrl #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_stall_o,
  input  logic [2:0]                    cmd_i,
  input  logic [slt_pkg::POS_W-1:0]     pos_i,
  input  logic [slt_pkg::KEY_W-1:0]     key_i,
  input  logic [PAYLOAD_BITS-1:0]       pay_i,
  input  logic [slt_pkg::CAP_W-1:0]     cap_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_stall_i,
  output slt_pkg::rsp_t                 rsp_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > slt_pkg::CAP_W) ? CNT_W : slt_pkg::CAP_W;
  localparam int KEY_W = slt_pkg::KEY_W;
  localparam int ENT_W = KEY_W + PAYLOAD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SHIFT,
    S_DRAIN,
    S_PLACE,
    S_READ,
    S_RESULT
  } state_e;

  state_e                    state_q, state_d;
  slt_pkg::cmd_e             cmd_q, cmd_d;
  logic [slt_pkg::POS_W-1:0] pos_q, pos_d;
  logic [KEY_W-1:0]          key_q, key_d;
  logic [PAYLOAD_BITS-1:0]   pay_q, pay_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [CNT_W-1:0]          where_q, where_d;
  logic [CNT_W-1:0]          ptr_q, ptr_d;
  logic [CNT_W-1:0]          idx_q, idx_d;
  logic                      rdv_q, rdv_d;
  logic                      up_q, up_d;
  slt_pkg::status_e          status_q, status_d;
  logic [KEY_W-1:0]          okkey_q, okkey_d;
  logic [PAYLOAD_BITS-1:0]   okpay_q, okpay_d;

  // Memory port signals.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENT_W-1:0] mem_rdata;

  // Derived values.
  logic [CMP_W-1:0]        cnt_x, cap_x, effcap, pos_x, where_x;
  logic                    full, empty, pos_bad;
  logic [CNT_W-1:0]        cnt_m1, cnt_p1, pos_cnt, rem_slot, last_ptr, ptr_step, idx_wr;
  logic [KEY_W-1:0]        rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [ENT_W-1:0]        new_ent;

  slt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Full check uses the capacity, saturated at DEPTH; position checks use the count.
  assign cnt_x   = CMP_W'(cnt_q);
  assign cap_x   = CMP_W'(cap_i);
  assign effcap  = (cap_x > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_x;
  assign full    = cnt_x >= effcap;
  assign empty   = (cnt_q == '0);
  assign pos_x   = CMP_W'(pos_q);
  assign pos_bad = pos_x >= cnt_x;
  assign pos_cnt = pos_x[CNT_W-1:0];
  assign where_x = CMP_W'(where_q);

  assign cnt_m1 = cnt_q - 1'b1;
  assign cnt_p1 = cnt_q + 1'b1;

  assign rd_key  = mem_rdata[ENT_W-1 -: KEY_W];
  assign rd_pay  = mem_rdata[PAYLOAD_BITS-1:0];
  assign new_ent = {key_q, pay_q};

  // Slot that a removal empties.
  always_comb begin
    unique case (cmd_q)
      slt_pkg::CMD_REM_END:   rem_slot = cnt_m1;
      slt_pkg::CMD_REM_FRONT: rem_slot = '0;
      default:                rem_slot = pos_cnt;
    endcase
  end

  // A shift moves entries up (towards the end) for inserts and down for removals.
  assign last_ptr = up_q ? where_q : cnt_m1;
  assign ptr_step = up_q ? (ptr_q - 1'b1) : (ptr_q + 1'b1);
  assign idx_wr   = up_q ? (idx_q + 1'b1) : (idx_q - 1'b1);

  // Next-state logic and memory port control.
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    pos_d    = pos_q;
    key_d    = key_q;
    pay_d    = pay_q;
    cnt_d    = cnt_q;
    where_d  = where_q;
    ptr_d    = ptr_q;
    idx_d    = idx_q;
    rdv_d    = rdv_q;
    up_d     = up_q;
    status_d = status_q;
    okkey_d  = okkey_q;
    okpay_d  = okpay_q;

    mem_we    = 1'b0;
    mem_waddr = idx_wr[IDX_W-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = ptr_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_d   = slt_pkg::cmd_e'(cmd_i);
          pos_d   = pos_i;
          key_d   = key_i;
          pay_d   = pay_i;
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        status_d  = slt_pkg::ST_OK;
        okkey_d   = '0;
        okpay_d   = '0;
        where_d   = '0;
        rdv_d     = 1'b0;
        mem_raddr = pos_x[IDX_W-1:0];
        state_d   = S_RESULT;
        unique case (cmd_q)
          slt_pkg::CMD_INS_END, slt_pkg::CMD_INS_FRONT, slt_pkg::CMD_INS_SORTED: begin
            priority if (full) begin
              status_d = slt_pkg::ST_FULL;
            end else if (cmd_q == slt_pkg::CMD_INS_END || empty) begin
              mem_we    = 1'b1;
              mem_waddr = cnt_q[IDX_W-1:0];
              mem_wdata = new_ent;
              where_d   = cnt_q;
              cnt_d     = cnt_p1;
            end else if (cmd_q == slt_pkg::CMD_INS_FRONT) begin
              up_d    = 1'b1;
              ptr_d   = cnt_m1;
              state_d = S_SHIFT;
            end else begin
              ptr_d   = '0;
              state_d = S_SCAN;
            end
          end
          slt_pkg::CMD_REM_END, slt_pkg::CMD_REM_FRONT, slt_pkg::CMD_REM_AT: begin
            priority if (empty) begin
              status_d = slt_pkg::ST_EMPTY;
            end else if (cmd_q == slt_pkg::CMD_REM_AT && pos_bad) begin
              status_d = slt_pkg::ST_BAD_POS;
            end else if (rem_slot == cnt_m1) begin
              where_d = rem_slot;
              cnt_d   = cnt_m1;
            end else begin
              where_d = rem_slot;
              up_d    = 1'b0;
              ptr_d   = rem_slot + 1'b1;
              state_d = S_SHIFT;
            end
          end
          slt_pkg::CMD_READ_AT: begin
            if (pos_bad) begin
              status_d = slt_pkg::ST_BAD_POS;
            end else begin
              where_d = pos_cnt;
              state_d = S_READ;
            end
          end
          slt_pkg::CMD_FIND_KEY: begin
            if (empty) begin
              status_d = slt_pkg::ST_NO_KEY;
            end else begin
              ptr_d   = '0;
              state_d = S_SCAN;
            end
          end
        endcase
      end

      // Ascending scan: a read is issued each cycle, its data checked in the next.
      S_SCAN: begin
        rdv_d = 1'b1;
        idx_d = ptr_q;
        ptr_d = ptr_q + 1'b1;
        if (rdv_q) begin
          if (cmd_q == slt_pkg::CMD_FIND_KEY) begin
            priority if (rd_key == key_q) begin
              where_d = idx_q;
              okkey_d = rd_key;
              okpay_d = rd_pay;
              state_d = S_RESULT;
            end else if (idx_q == cnt_m1) begin
              status_d = slt_pkg::ST_NO_KEY;
              state_d  = S_RESULT;
            end else begin
              // No match yet, so the scan moves on.
              state_d = S_SCAN;
            end
          end else begin
            priority if (!($signed(rd_key) < $signed(key_q))) begin
              where_d = idx_q;
              up_d    = 1'b1;
              ptr_d   = cnt_m1;
              rdv_d   = 1'b0;
              state_d = S_SHIFT;
            end else if (idx_q == cnt_m1) begin
              where_d = cnt_q;
              state_d = S_PLACE;
            end else begin
              // Every key so far is lower, so the scan moves on.
              state_d = S_SCAN;
            end
          end
        end
      end

      // Shift: read one entry per cycle and write the previous one to its neighbour slot.
      S_SHIFT: begin
        rdv_d  = 1'b1;
        idx_d  = ptr_q;
        ptr_d  = ptr_step;
        mem_we = rdv_q;
        if (ptr_q == last_ptr) begin
          state_d = S_DRAIN;
        end
      end

      // Write the last entry read by the shift.
      S_DRAIN: begin
        mem_we = 1'b1;
        if (up_q) begin
          state_d = S_PLACE;
        end else begin
          cnt_d   = cnt_m1;
          state_d = S_RESULT;
        end
      end

      // Store the new entry in the slot that was opened.
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = where_q[IDX_W-1:0];
        mem_wdata = new_ent;
        cnt_d     = cnt_p1;
        state_d   = S_RESULT;
      end

      S_READ: begin
        okkey_d = rd_key;
        okpay_d = rd_pay;
        state_d = S_RESULT;
      end

      S_RESULT: begin
        if (!rsp_stall_i) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= slt_pkg::CMD_INS_END;
      pos_q    <= '0;
      key_q    <= '0;
      pay_q    <= '0;
      cnt_q    <= '0;
      where_q  <= '0;
      ptr_q    <= '0;
      idx_q    <= '0;
      rdv_q    <= 1'b0;
      up_q     <= 1'b0;
      status_q <= slt_pkg::ST_OK;
      okkey_q  <= '0;
      okpay_q  <= '0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      pos_q    <= pos_d;
      key_q    <= key_d;
      pay_q    <= pay_d;
      cnt_q    <= cnt_d;
      where_q  <= where_d;
      ptr_q    <= ptr_d;
      idx_q    <= idx_d;
      rdv_q    <= rdv_d;
      up_q     <= up_d;
      status_q <= status_d;
      okkey_q  <= okkey_d;
      okpay_q  <= okpay_d;
    end
  end

  // Handshake and result record.
  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_RESULT);

  always_comb begin
    rsp_o                = '0;
    rsp_o.status         = status_q;
    rsp_o.found_position = where_x[slt_pkg::POS_W-1:0];
    rsp_o.key            = okkey_q;
    rsp_o.payload        = slt_pkg::PAY_MAX_W'(okpay_q);
    rsp_o.count          = cnt_x[slt_pkg::CNT_OUT_W-1:0];
    rsp_o.is_full        = full;
    rsp_o.is_empty       = empty;
  end

endmodule

### rtl/sequential_list_table.sv
// Sequential list table: a packed list of keyed records held in one synchronous entry memory.
// Top level with the capacity register and the output register; depends on slt_pkg and slt_ctrl.
//
// The block keeps up to DEPTH records (a signed 32-bit key and a PAYLOAD_BITS-bit payload) packed
// in slots 0 to count-1 of a single-port-write, registered-read RAM. Every command yields exactly
// one result. Commands are worked one at a time by a sequencer that moves one entry per cycle
// through the RAM, so the time per command depends on how many entries it touches. Inserts and
// removals at the end, an insert into an empty list and every rejected command shift or scan no
// entries; a find stops at its match. A new command is accepted as soon as the previous result
// has moved into the output register, even while that result is still stalled.
// The capacity register resets to 16 and should be written only while the block is idle.
module sequential_list_table #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                command_i,
  input  logic [3:0]                position_i,
  input  logic signed [31:0]        key_i,
  input  logic [PAYLOAD_BITS-1:0]   payload_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                status_o,
  output logic [3:0]                found_position_o,
  output logic signed [31:0]        out_key_o,
  output logic [PAYLOAD_BITS-1:0]   out_payload_o,
  output logic [4:0]                count_o,
  output logic                      is_full_o,
  output logic                      is_empty_o,
  input  logic                      cfg_we_i,
  input  logic [4:0]                cfg_wdata_i
);

  localparam logic [slt_pkg::CAP_W-1:0] CapReset = slt_pkg::CAP_W'(16);

  logic [slt_pkg::CAP_W-1:0] cap_q, cap_d;
  logic                      out_valid_q, out_valid_d;
  slt_pkg::rsp_t             out_q, out_d;
  logic                      rsp_valid;
  logic                      rsp_stall;
  slt_pkg::rsp_t             rsp;

  slt_ctrl #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .cmd_i       (command_i),
    .pos_i       (position_i),
    .key_i       (key_i),
    .pay_i       (payload_i),
    .cap_i       (cap_q),
    .rsp_valid_o (rsp_valid),
    .rsp_stall_i (rsp_stall),
    .rsp_o       (rsp)
  );

  // Capacity register, written directly by the configuration port.
  assign cap_d = cfg_we_i ? cfg_wdata_i : cap_q;

  // Output register: takes a new result when empty or when its current one is transferred.
  assign rsp_stall = out_valid_q && out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (rsp_valid && !rsp_stall) begin
      out_valid_d = 1'b1;
      out_d       = rsp;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // Result ports.
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign found_position_o = out_q.found_position;
  assign out_key_o        = out_q.key;
  assign out_payload_o    = out_q.payload[PAYLOAD_BITS-1:0];
  assign count_o          = out_q.count;
  assign is_full_o        = out_q.is_full;
  assign is_empty_o       = out_q.is_empty;

endmodule

### tb/sv/tb_top.sv
// Testbench for sequential_list_table: directed table, then random commands in capacity phases.
// Results are checked against typed rows or a list predictor updated per accepted transfer.
// Depends on slt_pkg and the sequential_list_table RTL only.
`timescale 1ns / 1ps

module tb_top;
  import slt_pkg::*;

  localparam int LIST_DEPTH   = 16;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 250;
  localparam int LONG_HOLD    = 80;
  localparam int SETTLE       = 20;

  // One row of the directed table; the expectation is used only when typed is set.
  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  pos;
    logic [31:0] key;
    logic [63:0] pay;
    logic        typed;
    rsp_t        want;
  } dir_row_t;

  // Results that can be read straight off an empty or nearly empty list.
  localparam rsp_t RSP_EMPTY_REJECT = '{ST_EMPTY, 4'd0, 32'h0, 64'h0, 5'd0, 1'b0, 1'b1};
  localparam rsp_t RSP_READ_EMPTY   = '{ST_BAD_POS, 4'd0, 32'h0, 64'h0, 5'd0, 1'b0, 1'b1};
  localparam rsp_t RSP_FIND_EMPTY   = '{ST_NO_KEY, 4'd0, 32'h0, 64'h0, 5'd0, 1'b0, 1'b1};
  localparam rsp_t RSP_FIRST_INSERT = '{ST_OK, 4'd0, 32'h0, 64'h0, 5'd1, 1'b0, 1'b0};
  localparam rsp_t RSP_FRONT_SECOND = '{ST_OK, 4'd0, 32'h0, 64'h0, 5'd2, 1'b0, 1'b0};

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_REM_END,    4'd0,  32'h0000_0000, 64'h0, 1'b1, RSP_EMPTY_REJECT},
    '{CMD_REM_FRONT,  4'd0,  32'h0000_0000, 64'h0, 1'b1, RSP_EMPTY_REJECT},
    '{CMD_REM_AT,     4'd15, 32'h0000_0000, 64'h0, 1'b1, RSP_EMPTY_REJECT},
    '{CMD_READ_AT,    4'd0,  32'h0000_0000, 64'h0, 1'b1, RSP_READ_EMPTY},
    '{CMD_FIND_KEY,   4'd0,  32'h0000_0000, 64'h0, 1'b1, RSP_FIND_EMPTY},
    '{CMD_INS_END,    4'd0,  32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, RSP_FIRST_INSERT},
    '{CMD_INS_FRONT,  4'd0,  32'h8000_0000, 64'h0, 1'b1, RSP_FRONT_SECOND},
    '{CMD_INS_SORTED, 4'd0,  32'h0000_0000, 64'h5555_5555_5555_5555, 1'b0, '0},
    '{CMD_INS_SORTED, 4'd0,  32'h0000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    '{CMD_INS_SORTED, 4'd0,  32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
    '{CMD_INS_SORTED, 4'd0,  32'h7FFF_FFFF, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
    '{CMD_INS_SORTED, 4'd0,  32'h8000_0000, 64'h0000_0000_0000_0001, 1'b0, '0},
    '{CMD_READ_AT,    4'd0,  32'h0000_0000, 64'h0, 1'b0, '0},
    '{CMD_READ_AT,    4'd15, 32'h0000_0000, 64'h0, 1'b0, '0},
    '{CMD_READ_AT,    4'd7,  32'h0000_0000, 64'h0, 1'b0, '0},
    '{CMD_FIND_KEY,   4'd0,  32'h0000_0000, 64'h0, 1'b0, '0},
    '{CMD_FIND_KEY,   4'd0,  32'h1234_5678, 64'h0, 1'b0, '0},
    '{CMD_REM_AT,     4'd6,  32'h0000_0000, 64'h0, 1'b0, '0},
    '{CMD_REM_AT,     4'd2,  32'h0000_0000, 64'h0, 1'b0, '0},
    '{CMD_REM_AT,     4'd7,  32'h0000_0000, 64'h0, 1'b0, '0},
    '{CMD_REM_FRONT,  4'd0,  32'h0000_0000, 64'h0, 1'b0, '0},
    '{CMD_REM_END,    4'd0,  32'h0000_0000, 64'h0, 1'b0, '0},
    '{CMD_READ_AT,    4'd1,  32'h0000_0000, 64'h0, 1'b0, '0},
    '{CMD_FIND_KEY,   4'd0,  32'h7FFF_FFFF, 64'h0, 1'b0, '0}
  };

  // Capacity and idling per random phase; the last phase runs without gaps.
  localparam logic [4:0] PHASE_CAP [PHASES] = '{5'd31, 5'd1, 5'd0, 5'd7, 5'd16, 5'd9, 5'd17, 5'd3};
  localparam int TX_IDLE_PCT [PHASES] = '{20, 30, 0, 15, 25, 10, 20, 0};
  localparam int RX_IDLE_PCT [PHASES] = '{8, 12, 0, 6, 10, 4, 8, 0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = CMD_INS_END;
  logic [3:0]  position_i = 4'd0;
  logic signed [31:0] key_i = 32'sd0;
  logic [63:0] payload_i = 64'h0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  found_position_o;
  logic signed [31:0] out_key_o;
  logic [63:0] out_payload_o;
  logic [4:0]  count_o;
  logic        is_full_o;
  logic        is_empty_o;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = 5'd0;

  // Predictor state: a copy of the list and of the capacity register.
  logic signed [31:0] list_keys [LIST_DEPTH];
  logic [63:0]        list_pays [LIST_DEPTH];
  int                 list_len = 0;
  logic [4:0]         cap_reg = 5'd16;

  rsp_t awaited_results [$];
  int   fail_count = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  bit   hold_armed = 1'b0;
  bit   hold_done = 1'b0;

  sequential_list_table #(
    .DEPTH        (LIST_DEPTH),
    .PAYLOAD_BITS (64)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .position_i       (position_i),
    .key_i            (key_i),
    .payload_i        (payload_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .out_key_o        (out_key_o),
    .out_payload_o    (out_payload_o),
    .count_o          (count_o),
    .is_full_o        (is_full_o),
    .is_empty_o       (is_empty_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Applies one command to the predicted list and returns the result it should produce.
  function automatic rsp_t apply_command(cmd_e cmd, logic [3:0] pos,
                                         logic signed [31:0] key, logic [63:0] pay);
    rsp_t res;
    int   eff_cap;
    int   slot;
    int   i;
    res = '0;
    res.status = ST_OK;
    eff_cap = (cap_reg > LIST_DEPTH) ? LIST_DEPTH : int'(cap_reg);
    slot = 0;
    case (cmd)
      CMD_INS_END, CMD_INS_FRONT, CMD_INS_SORTED: begin
        if (list_len >= eff_cap) begin
          res.status = ST_FULL;
        end else begin
          if (cmd == CMD_INS_END) begin
            slot = list_len;
          end else if (cmd == CMD_INS_SORTED) begin
            // Equal keys go in front of the ones already held.
            while (slot < list_len && list_keys[slot] < key) slot++;
          end
          for (i = list_len; i > slot; i--) begin
            list_keys[i] = list_keys[i-1];
            list_pays[i] = list_pays[i-1];
          end
          list_keys[slot] = key;
          list_pays[slot] = pay;
          list_len++;
        end
      end
      CMD_REM_END, CMD_REM_FRONT, CMD_REM_AT: begin
        // The empty test comes before the position test.
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (cmd == CMD_REM_AT && pos >= list_len) begin
          res.status = ST_BAD_POS;
        end else begin
          if (cmd == CMD_REM_END) slot = list_len - 1;
          else if (cmd == CMD_REM_AT) slot = pos;
          for (i = slot; i + 1 < list_len; i++) begin
            list_keys[i] = list_keys[i+1];
            list_pays[i] = list_pays[i+1];
          end
          list_len--;
        end
      end
      CMD_READ_AT: begin
        if (pos >= list_len) begin
          res.status = ST_BAD_POS;
        end else begin
          slot = pos;
          res.key = list_keys[slot];
          res.payload = list_pays[slot];
        end
      end
      default: begin
        slot = 0;
        while (slot < list_len && list_keys[slot] != key) slot++;
        if (slot >= list_len) begin
          res.status = ST_NO_KEY;
        end else begin
          res.key = list_keys[slot];
          res.payload = list_pays[slot];
        end
      end
    endcase
    if (res.status != ST_OK) slot = 0;
    res.found_position = slot[3:0];
    res.count = list_len[4:0];
    res.is_full = (list_len >= eff_cap);
    res.is_empty = (list_len == 0);
    return res;
  endfunction

  // Offers one command, holds it until the transfer, then maybe leaves a gap.
  task automatic send_command(cmd_e cmd, logic [3:0] pos, logic signed [31:0] key,
                              logic [63:0] pay, logic typed, rsp_t want);
    rsp_t predicted;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    position_i <= pos;
    key_i <= key;
    payload_i <= pay;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_command(cmd, pos, key, pay);
    awaited_results.push_back(typed ? want : predicted);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits for every outstanding result to be taken.
  task automatic drain_list(int extra);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = value;
  endtask

  // Inserts are favoured while filling so the list reaches full, removals while draining.
  function automatic cmd_e pick_command(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < (filling ? 65 : 25)) begin
      case ($urandom_range(0, 3))
        0:       return CMD_INS_END;
        1:       return CMD_INS_FRONT;
        default: return CMD_INS_SORTED;
      endcase
    end
    case ($urandom_range(0, 4))
      0:       return CMD_REM_END;
      1:       return CMD_REM_FRONT;
      2:       return CMD_REM_AT;
      3:       return CMD_READ_AT;
      default: return CMD_FIND_KEY;
    endcase
  endfunction

  // Keys come mostly from a narrow pool so that sorted inserts meet equal keys and finds hit.
  function automatic logic [31:0] pick_key(bit for_find);
    int r;
    r = $urandom_range(0, 99);
    if (for_find && list_len > 0 && r < 60) return list_keys[$urandom_range(0, list_len - 1)];
    if (r < 5) return 32'h7FFF_FFFF;
    if (r < 10) return 32'h8000_0000;
    if (r < 55) return 32'($urandom_range(0, 6)) - 32'd3;
    return $urandom;
  endfunction

  function automatic logic [3:0] pick_position();
    if (list_len > 0 && $urandom_range(0, 99) < 70) return 4'($urandom_range(0, list_len));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off that lets the block fill up.
  initial begin : result_stall
    forever begin
      @(posedge clk_i);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Each result transfer is compared with the oldest outstanding expectation.
  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("found_position", want.found_position, found_position_o);
        check_field("out_key", want.key, $unsigned(out_key_o));
        check_field("out_payload", want.payload, out_payload_o);
        check_field("count", want.count, count_o);
        check_field("is_full", want.is_full, is_full_o);
        check_field("is_empty", want.is_empty, is_empty_o);
      end
    end
  end

  // Stimulus: reset, the directed table, then the random phases.
  initial begin : stimulus
    cmd_e       cmd;
    logic [4:0] cap;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    tx_idle_pct = 20;
    rx_idle_pct = 6;
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_command(DIRECTED[r].cmd, DIRECTED[r].pos, DIRECTED[r].key, DIRECTED[r].pay,
                   DIRECTED[r].typed, DIRECTED[r].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // The sender pauses here until every result is back, so the register write is idle.
      drain_list(4);
      cap = (ph == 5) ? 5'($urandom_range(2, 15)) : PHASE_CAP[ph];
      write_capacity(cap);
      tx_idle_pct = TX_IDLE_PCT[ph];
      rx_idle_pct = RX_IDLE_PCT[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 100) hold_armed = 1'b1;
        cmd = pick_command(((n / 40) % 2) == 0);
        send_command(cmd, pick_position(), pick_key(cmd == CMD_FIND_KEY),
                     {$urandom, $urandom}, 1'b0, '0);
      end
    end

    drain_list(SETTLE);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin : watchdog
    #3_000_000;
    $error("timed out with %0d results outstanding", awaited_results.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
